### rtl/annexb_to_length_prefixed_nal_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the length-prefixed NAL converter.
// ---------------------------------------------------------------------------
`ifndef ANNEXB_TO_LENGTH_PREFIXED_NAL_MACROS_SVH
`define ANNEXB_TO_LENGTH_PREFIXED_NAL_MACROS_SVH

// same-cycle implication, held off during reset
`define A2LP_ASSERT_IMP(label, ant, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define A2LP_ASSERT_NXT(label, ant, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (cons)) \
        else $error(msg);

`endif

### rtl/a2lp_pkg.sv
// ---------------------------------------------------------------------------
// a2lp_pkg
// Sizes and shared types of the length-prefixed NAL converter.
// ---------------------------------------------------------------------------
package a2lp_pkg;

    localparam int PKT_DEPTH   = 4096;
    localparam int NAL_SLOTS   = 16;

    localparam int PKT_AW      = $clog2(PKT_DEPTH);
    localparam int CNT_W       = PKT_AW + 1;
    localparam int NAL_AW      = (NAL_SLOTS > 1) ? $clog2(NAL_SLOTS) : 1;
    localparam int NAL_CW      = $clog2(NAL_SLOTS + 1);

    localparam int LEN_BYTES   = 4;
    localparam int ZRUN_MAX    = 2;
    localparam logic [7:0] START_BYTE = 8'h01;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PULL  = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] nal_begin;
        logic [CNT_W-1:0] nal_end;
    } nal_entry_t;

    localparam int NAL_ENTRY_W = 2 * CNT_W;

endpackage

### rtl/a2lp_ram.sv
// ---------------------------------------------------------------------------
// a2lp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module a2lp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/annexb_to_length_prefixed_nal.sv
// ---------------------------------------------------------------------------
// annexb_to_length_prefixed_nal
// Loads one Annex B packet, then plays it out with 4-byte length prefixes.
// ---------------------------------------------------------------------------
// Each slave word is a load (tuser = 0) or a pull (tuser = 1); every pull
// returns exactly one master word, loads return none. After the load word
// with tlast the block closes the open NAL in ST_CLOSE. An empty packet then
// returns to loading, a packet without a non-empty NAL plays out raw at once;
// otherwise the block scans the NAL table (read in ST_SCAN_RD, checked in
// ST_SCAN_CHK) up to the first non-empty NAL and the next non-empty one after
// it, or to the end of the table, before it takes pulls. A pull of a length
// byte is answered from ST_EMIT; a pull of a payload or raw byte goes through
// the packet memory read in ST_FETCH. Crossing into the next NAL scans the
// table again from that NAL onward in the same way. No slave word is taken
// while a master word is held. Pulls during loading return tuser[0] = 0;
// loads during playout are dropped. There is no clearing pass after reset.
// ---------------------------------------------------------------------------
`include "annexb_to_length_prefixed_nal_macros.svh"

module annexb_to_length_prefixed_nal (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tlast,   // last_byte
    input  logic       s_tuser,   // req_type
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // out_last
    output logic [1:0] m_tuser    // out_valid, out_overflow
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CLOSE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT,
        ST_FETCH
    } state_t;

    state_t state_reg, state_next;

    logic [a2lp_pkg::CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [a2lp_pkg::NAL_CW-1:0] nal_count_reg, nal_count_next;
    logic [1:0]                  zero_run_reg, zero_run_next;
    logic [a2lp_pkg::CNT_W-1:0]  last_nz_reg, last_nz_next;
    logic [a2lp_pkg::CNT_W-1:0]  open_begin_reg, open_begin_next;
    logic                        overflow_reg, overflow_next;
    logic                        saw_nz_reg, saw_nz_next;
    logic                        raw_reg, raw_next;
    logic [a2lp_pkg::NAL_CW-1:0] scan_idx_reg, scan_idx_next;
    logic                        looking_reg, looking_next;
    logic [a2lp_pkg::NAL_CW-1:0] nxt_reg, nxt_next;
    logic [a2lp_pkg::CNT_W-1:0]  cur_begin_reg, cur_begin_next;
    logic [a2lp_pkg::CNT_W-1:0]  cur_size_reg, cur_size_next;
    logic [a2lp_pkg::CNT_W-1:0]  ptr_reg, ptr_next;
    logic [2:0]                  prefix_reg, prefix_next;
    logic                        fin_reg, fin_next;
    logic                        last_pend_reg, last_pend_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [7:0]                  out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_ovf_reg, out_ovf_next;

    logic                        pkt_we, pkt_re;
    logic [a2lp_pkg::PKT_AW-1:0] pkt_waddr, pkt_raddr;
    logic [7:0]                  pkt_rdata;

    logic                        tab_we, tab_re;
    logic [a2lp_pkg::NAL_AW-1:0] tab_waddr, tab_raddr;
    a2lp_pkg::nal_entry_t        tab_wdata, tab_rdata;
    logic [a2lp_pkg::NAL_ENTRY_W-1:0] tab_rdata_raw;

    logic                        s_acc;
    logic                        clear_pkt;
    logic                        nz_last;
    logic [a2lp_pkg::NAL_CW-1:0] close_idx;
    logic [a2lp_pkg::CNT_W-1:0]  byte_count_inc;
    logic [a2lp_pkg::CNT_W-1:0]  ptr_inc;
    logic [31:0]                 len_word;
    logic [4:0]                  len_shift;
    logic [7:0]                  len_byte;

    assign s_tready = ((state_reg == ST_LOAD) || (state_reg == ST_EMIT))
                      && (!m_tvalid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_ovf_reg, out_valid_reg};

    assign close_idx      = nal_count_reg - a2lp_pkg::NAL_CW'(1);
    assign byte_count_inc = byte_count_reg + a2lp_pkg::CNT_W'(1);
    assign ptr_inc        = ptr_reg + a2lp_pkg::CNT_W'(1);
    assign len_word       = 32'(cur_size_reg);
    assign len_shift      = {~prefix_reg[1:0], 3'b000};
    assign len_byte       = 8'(len_word >> len_shift);
    assign tab_rdata      = a2lp_pkg::nal_entry_t'(tab_rdata_raw);
    assign nz_last        = (nal_count_reg != '0) && (last_nz_reg > open_begin_reg);

    a2lp_ram #(
        .WIDTH (8),
        .DEPTH (a2lp_pkg::PKT_DEPTH)
    ) u_pkt_ram (
        .aclk  (aclk),
        .we    (pkt_we),
        .waddr (pkt_waddr),
        .wdata (s_tdata),
        .re    (pkt_re),
        .raddr (pkt_raddr),
        .rdata (pkt_rdata)
    );

    a2lp_ram #(
        .WIDTH (a2lp_pkg::NAL_ENTRY_W),
        .DEPTH (a2lp_pkg::NAL_SLOTS)
    ) u_nal_ram (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .re    (tab_re),
        .raddr (tab_raddr),
        .rdata (tab_rdata_raw)
    );

    always_comb begin
        state_next      = state_reg;
        byte_count_next = byte_count_reg;
        nal_count_next  = nal_count_reg;
        zero_run_next   = zero_run_reg;
        last_nz_next    = last_nz_reg;
        open_begin_next = open_begin_reg;
        overflow_next   = overflow_reg;
        saw_nz_next     = saw_nz_reg;
        raw_next        = raw_reg;
        scan_idx_next   = scan_idx_reg;
        looking_next    = looking_reg;
        nxt_next        = nxt_reg;
        cur_begin_next  = cur_begin_reg;
        cur_size_next   = cur_size_reg;
        ptr_next        = ptr_reg;
        prefix_next     = prefix_reg;
        fin_next        = fin_reg;
        last_pend_next  = last_pend_reg;

        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg;
        out_ovf_next    = out_ovf_reg;

        pkt_we          = 1'b0;
        pkt_waddr       = byte_count_reg[a2lp_pkg::PKT_AW-1:0];
        pkt_re          = 1'b0;
        pkt_raddr       = ptr_reg[a2lp_pkg::PKT_AW-1:0];
        tab_we          = 1'b0;
        tab_waddr       = close_idx[a2lp_pkg::NAL_AW-1:0];
        tab_wdata.nal_begin = open_begin_reg;
        tab_wdata.nal_end   = last_nz_reg;
        tab_re          = 1'b0;
        tab_raddr       = scan_idx_reg[a2lp_pkg::NAL_AW-1:0];
        clear_pkt       = 1'b0;

        case (state_reg)
            ST_LOAD: begin
                if (s_acc && (s_tuser == a2lp_pkg::REQ_PULL)) begin
                    m_tvalid_next  = 1'b1;
                    out_data_next  = '0;
                    out_last_next  = 1'b0;
                    out_valid_next = 1'b0;
                    out_ovf_next   = 1'b0;
                end else if (s_acc) begin
                    if (!overflow_reg) begin
                        if (byte_count_reg >= a2lp_pkg::CNT_W'(a2lp_pkg::PKT_DEPTH)) begin
                            overflow_next = 1'b1;
                        end else begin
                            pkt_we          = 1'b1;
                            byte_count_next = byte_count_inc;
                            if ((s_tdata == a2lp_pkg::START_BYTE)
                                && (zero_run_reg == 2'(a2lp_pkg::ZRUN_MAX))) begin
                                if (nal_count_reg != '0) begin
                                    tab_we = 1'b1;
                                    if (last_nz_reg > open_begin_reg) begin
                                        saw_nz_next = 1'b1;
                                    end
                                end
                                if (nal_count_reg < a2lp_pkg::NAL_CW'(a2lp_pkg::NAL_SLOTS)) begin
                                    open_begin_next = byte_count_inc;
                                    last_nz_next    = byte_count_inc;
                                    nal_count_next  = nal_count_reg + a2lp_pkg::NAL_CW'(1);
                                    zero_run_next   = '0;
                                end else begin
                                    overflow_next = 1'b1;
                                end
                            end else if (s_tdata == 8'h00) begin
                                if (zero_run_reg < 2'(a2lp_pkg::ZRUN_MAX)) begin
                                    zero_run_next = zero_run_reg + 2'd1;
                                end
                            end else begin
                                zero_run_next = '0;
                                last_nz_next  = byte_count_inc;
                            end
                        end
                    end
                    if (s_tlast) begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE: begin
                if (nal_count_reg != '0) begin
                    tab_we = 1'b1;
                end
                saw_nz_next = saw_nz_reg || nz_last;
                ptr_next    = '0;
                prefix_next = '0;
                if (!(saw_nz_reg || nz_last)) begin
                    if (byte_count_reg == '0) begin
                        clear_pkt = 1'b1;
                    end else begin
                        raw_next   = 1'b1;
                        state_next = ST_EMIT;
                    end
                end else begin
                    scan_idx_next = '0;
                    looking_next  = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (scan_idx_reg >= nal_count_reg) begin
                    nxt_next   = nal_count_reg;
                    state_next = ST_EMIT;
                end else begin
                    tab_re     = 1'b1;
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                if ((tab_rdata.nal_end > tab_rdata.nal_begin) && !looking_reg) begin
                    nxt_next   = scan_idx_reg;
                    state_next = ST_EMIT;
                end else begin
                    if (tab_rdata.nal_end > tab_rdata.nal_begin) begin
                        cur_begin_next = tab_rdata.nal_begin;
                        cur_size_next  = tab_rdata.nal_end - tab_rdata.nal_begin;
                        looking_next   = 1'b0;
                    end
                    scan_idx_next = scan_idx_reg + a2lp_pkg::NAL_CW'(1);
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_EMIT: begin
                if (s_acc && (s_tuser == a2lp_pkg::REQ_PULL)) begin
                    if (raw_reg) begin
                        pkt_re         = 1'b1;
                        ptr_next       = ptr_inc;
                        fin_next       = (ptr_inc >= byte_count_reg);
                        last_pend_next = (ptr_inc >= byte_count_reg);
                        state_next     = ST_FETCH;
                    end else if (prefix_reg < 3'(a2lp_pkg::LEN_BYTES)) begin
                        m_tvalid_next  = 1'b1;
                        out_data_next  = len_byte;
                        out_last_next  = 1'b0;
                        out_valid_next = 1'b1;
                        out_ovf_next   = overflow_reg;
                        prefix_next    = prefix_reg + 3'd1;
                    end else begin
                        pkt_re         = 1'b1;
                        pkt_raddr      = cur_begin_reg[a2lp_pkg::PKT_AW-1:0]
                                         + ptr_reg[a2lp_pkg::PKT_AW-1:0];
                        ptr_next       = ptr_inc;
                        fin_next       = (ptr_inc >= cur_size_reg);
                        last_pend_next = (ptr_inc >= cur_size_reg)
                                         && (nxt_reg >= nal_count_reg);
                        state_next     = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                m_tvalid_next  = 1'b1;
                out_data_next  = pkt_rdata;
                out_last_next  = last_pend_reg;
                out_valid_next = 1'b1;
                out_ovf_next   = overflow_reg;
                if (fin_reg && last_pend_reg) begin
                    clear_pkt = 1'b1;
                end else if (fin_reg) begin
                    scan_idx_next = nxt_reg;
                    looking_next  = 1'b1;
                    ptr_next      = '0;
                    prefix_next   = '0;
                    state_next    = ST_SCAN_RD;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        if (clear_pkt) begin
            byte_count_next = '0;
            nal_count_next  = '0;
            zero_run_next   = '0;
            last_nz_next    = '0;
            open_begin_next = '0;
            overflow_next   = 1'b0;
            saw_nz_next     = 1'b0;
            raw_next        = 1'b0;
            ptr_next        = '0;
            prefix_next     = '0;
            state_next      = ST_LOAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            byte_count_reg <= '0;
            nal_count_reg  <= '0;
            zero_run_reg   <= '0;
            last_nz_reg    <= '0;
            open_begin_reg <= '0;
            overflow_reg   <= 1'b0;
            saw_nz_reg     <= 1'b0;
            raw_reg        <= 1'b0;
            scan_idx_reg   <= '0;
            looking_reg    <= 1'b0;
            nxt_reg        <= '0;
            cur_begin_reg  <= '0;
            cur_size_reg   <= '0;
            ptr_reg        <= '0;
            prefix_reg     <= '0;
            fin_reg        <= 1'b0;
            last_pend_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            out_data_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_ovf_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
            nal_count_reg  <= nal_count_next;
            zero_run_reg   <= zero_run_next;
            last_nz_reg    <= last_nz_next;
            open_begin_reg <= open_begin_next;
            overflow_reg   <= overflow_next;
            saw_nz_reg     <= saw_nz_next;
            raw_reg        <= raw_next;
            scan_idx_reg   <= scan_idx_next;
            looking_reg    <= looking_next;
            nxt_reg        <= nxt_next;
            cur_begin_reg  <= cur_begin_next;
            cur_size_reg   <= cur_size_next;
            ptr_reg        <= ptr_next;
            prefix_reg     <= prefix_next;
            fin_reg        <= fin_next;
            last_pend_reg  <= last_pend_next;
            m_tvalid_reg   <= m_tvalid_next;
            out_data_reg   <= out_data_next;
            out_last_reg   <= out_last_next;
            out_valid_reg  <= out_valid_next;
            out_ovf_reg    <= out_ovf_next;
        end
    end

    `A2LP_ASSERT_IMP(a_fetch_slot_free, state_reg == ST_FETCH, !m_tvalid_reg,
        "output word still held when packet memory data returns")
    `A2LP_ASSERT_IMP(a_counts_bounded, 1'b1,
        (byte_count_reg <= a2lp_pkg::CNT_W'(a2lp_pkg::PKT_DEPTH))
        && (nal_count_reg <= a2lp_pkg::NAL_CW'(a2lp_pkg::NAL_SLOTS)),
        "byte or NAL count beyond capacity")
    `A2LP_ASSERT_IMP(a_emit_size_nonzero, (state_reg == ST_EMIT) && !raw_reg,
        cur_size_reg != '0, "playout of an empty NAL")
    `A2LP_ASSERT_NXT(a_last_returns_to_load, (state_reg == ST_FETCH) && last_pend_reg,
        (state_reg == ST_LOAD) && (byte_count_reg == '0) && !overflow_reg,
        "packet state not cleared after final word")

endmodule
